/* hdl/sccc_pkg.sv */
package sccc_pkg;

  // Field widths
  localparam int unsigned VAL_W      = 20;
  localparam int unsigned NOW_W      = 32;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned OUT_DATA_W = 88;

  // Default time width for the elapsed-time arithmetic
  localparam int unsigned TIME_WIDTH_DEF = 32;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_US   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CATCH_UP    = 8'd2;

  // Register reset values
  localparam logic [VAL_W-1:0] DEF_SAMPLE_RATE = 20'd1000;
  localparam logic [VAL_W-1:0] DEF_PERIOD_US   = 20'd1000;
  localparam logic             DEF_CATCH_UP    = 1'b1;

  // Command codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* hdl/sccc_div.sv */
// Restoring divider, one quotient bit per cycle, 20-bit divisor.
module sccc_div #(
  parameter int unsigned DIV_W = sccc_pkg::TIME_WIDTH_DEF + 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [DIV_W-1:0]          dividend,
  input  logic [sccc_pkg::VAL_W-1:0] divisor,
  output sccc_pkg::div_stat_t       stat,
  output logic [DIV_W-1:0]          quotient,
  output logic [sccc_pkg::VAL_W-1:0] remainder
);

  localparam int unsigned CW = $clog2(DIV_W + 1);

  logic                       busy_r;
  logic                       done_r;
  logic [CW-1:0]              cnt_r;
  logic [DIV_W-1:0]           quo_r;
  logic [sccc_pkg::VAL_W-1:0] rem_r;
  logic [sccc_pkg::VAL_W-1:0] dsr_r;

  logic [sccc_pkg::VAL_W:0]   trial;
  logic [sccc_pkg::VAL_W:0]   diff;
  logic                       fits;

  // Trial subtract of the shifted partial remainder
  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign fits  = (trial >= {1'b0, dsr_r});

  // Control: count down one bit a cycle, pulse done at the end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift dividend out, quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_W-2:0], fits};
      rem_r <= fits ? diff[sccc_pkg::VAL_W-1:0] : trial[sccc_pkg::VAL_W-1:0];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

  // Checks
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < dsr_r))
    else $error("divider remainder not below divisor");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("divider did not start");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(busy_r) && !busy_r))
    else $error("divider done without a run");

endmodule

/* hdl/sample_clock_catchup_counter.sv */
// Fixed-rate sample clock with catch-up. Each input word is a tick or a start command with a
// free-running microsecond timestamp; every command returns one result word with the new-sample
// flag, the sample index, the seconds count and the total sample count. One command is worked on
// at a time and in_tready is high only while the block is idle. A start passes through the multiply
// and done states; a tick that does not fire passes through evaluate, multiply and done. A firing
// tick runs the shared restoring divider: in simple mode once ((index + 1) modulo rate); in
// catch-up mode twice (overrun by period, then (index + whole periods + 1) modulo rate). The
// divider produces one quotient bit per cycle. Configuration writes are taken at any time and
// should be made while idle.
module sample_clock_catchup_counter #(
  parameter int unsigned TIME_WIDTH = sccc_pkg::TIME_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: now_us[31:0]
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sccc_pkg::NOW_W-1:0]      in_tdata,
  // in_tuser: opcode[0]
  input  logic [0:0]                      in_tuser,
  // out_tdata: sample_index[19:0], seconds_count[51:20], total_samples[83:52], zero[87:84]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sccc_pkg::OUT_DATA_W-1:0] out_tdata,
  // out_tuser: new_sample[0]
  output logic [0:0]                      out_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sccc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sccc_pkg::VAL_W-1:0]      cfg_data
);

  localparam int unsigned TW    = TIME_WIDTH;
  localparam int unsigned VW    = sccc_pkg::VAL_W;
  localparam int unsigned DIV_W = ((TW > VW) ? TW : VW) + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_DIV1 = 3'd2;
  localparam logic [2:0] S_DIV2 = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  // Configuration registers
  logic [VW-1:0] sample_rate_r;
  logic [VW-1:0] period_us_r;
  logic          catch_up_r;

  // Sequencer and clock state
  logic [2:0]                    state_r, state_nxt;
  logic [TW-1:0]                 last_time_r, last_time_nxt;
  logic [TW-1:0]                 time_left_r, time_left_nxt;
  logic [VW-1:0]                 index_r, index_nxt;
  logic [sccc_pkg::CNT_W-1:0]    seconds_r, seconds_nxt;
  logic [TW-1:0]                 elapsed_r, elapsed_nxt;
  logic [TW-1:0]                 now_r, now_nxt;
  logic                          fired_r, fired_nxt;
  logic [sccc_pkg::CNT_W-1:0]    prod_r, prod_nxt;

  // Result register
  logic                          out_valid_r;
  logic                          out_fired_r;
  logic [VW-1:0]                 out_idx_r;
  logic [sccc_pkg::CNT_W-1:0]    out_sec_r;
  logic [sccc_pkg::CNT_W-1:0]    out_tot_r;

  // Divider hookup
  logic                          div_start;
  logic [DIV_W-1:0]              div_dividend;
  logic [VW-1:0]                 div_divisor;
  sccc_pkg::div_stat_t           div_stat;
  logic [DIV_W-1:0]              div_quo;
  logic [VW-1:0]                 div_rem;

  // Derived values
  logic [VW-1:0]                 eff_rate;
  logic [VW-1:0]                 eff_per;
  logic [TW+sccc_pkg::NOW_W-1:0] now_ext;
  logic [TW+VW-1:0]              per_ext;
  logic [TW+VW-1:0]              per_rem_ext;
  logic [VW-1:0]                 per_rem;
  logic [TW:0]                   delay_w;
  logic [TW-1:0]                 shrink;
  logic [DIV_W-1:0]              idx_ext;
  logic [VW+sccc_pkg::CNT_W-1:0] mul_full;
  logic                          in_acc;
  logic                          out_free;

  assign eff_rate    = (sample_rate_r == '0) ? VW'(1) : sample_rate_r;
  assign eff_per     = (period_us_r == '0) ? VW'(1) : period_us_r;
  assign now_ext     = {{TW{1'b0}}, in_tdata};
  assign per_ext     = {{TW{1'b0}}, eff_per};
  assign per_rem     = eff_per - div_rem;
  assign per_rem_ext = {{TW{1'b0}}, per_rem};
  assign delay_w     = {1'b0, elapsed_r} - {1'b0, time_left_r};
  assign shrink      = time_left_r - elapsed_r;
  assign idx_ext     = {{(DIV_W-VW){1'b0}}, index_r};
  assign mul_full    = seconds_r * eff_rate;
  assign in_acc      = in_tvalid && in_tready;
  assign out_free    = !out_valid_r || out_tready;

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_rate_r <= sccc_pkg::DEF_SAMPLE_RATE;
      period_us_r   <= sccc_pkg::DEF_PERIOD_US;
      catch_up_r    <= sccc_pkg::DEF_CATCH_UP;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sccc_pkg::REG_SAMPLE_RATE: sample_rate_r <= cfg_data;
        sccc_pkg::REG_PERIOD_US:   period_us_r   <= cfg_data;
        sccc_pkg::REG_CATCH_UP:    catch_up_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    last_time_nxt = last_time_r;
    time_left_nxt = time_left_r;
    index_nxt     = index_r;
    seconds_nxt   = seconds_r;
    elapsed_nxt   = elapsed_r;
    now_nxt       = now_r;
    fired_nxt     = fired_r;
    prod_nxt      = prod_r;
    div_start     = 1'b0;
    div_dividend  = {{(DIV_W-TW){1'b0}}, delay_w[TW-1:0]};
    div_divisor   = eff_per;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          fired_nxt = 1'b0;
          if (in_tuser[0] == sccc_pkg::OP_START) begin
            // Restart: clear index, reload period, record time
            index_nxt     = '0;
            time_left_nxt = per_ext[TW-1:0];
            last_time_nxt = now_ext[TW-1:0];
            state_nxt     = S_MUL;
          end else begin
            elapsed_nxt = now_ext[TW-1:0] - last_time_r;
            now_nxt     = now_ext[TW-1:0];
            state_nxt   = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        last_time_nxt = now_r;
        if (delay_w[TW]) begin
          // Not yet due: shrink remaining time
          time_left_nxt = shrink;
          state_nxt     = S_MUL;
        end else if (catch_up_r) begin
          // Split the overrun into whole periods and remainder
          div_start = 1'b1;
          state_nxt = S_DIV1;
        end else begin
          time_left_nxt = per_ext[TW-1:0];
          div_start     = 1'b1;
          div_dividend  = idx_ext + DIV_W'(1);
          div_divisor   = eff_rate;
          state_nxt     = S_DIV2;
        end
      end
      S_DIV1: begin
        if (div_stat.done) begin
          time_left_nxt = per_rem_ext[TW-1:0];
          div_start     = 1'b1;
          div_dividend  = idx_ext + div_quo + DIV_W'(1);
          div_divisor   = eff_rate;
          state_nxt     = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_stat.done) begin
          // Wrap the index and count a second when it went backwards
          index_nxt = div_rem;
          if (div_rem < index_r) begin
            seconds_nxt = seconds_r + sccc_pkg::CNT_W'(1);
          end
          fired_nxt = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = mul_full[sccc_pkg::CNT_W-1:0];
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_time_r <= '0;
      time_left_r <= '0;
      index_r     <= '0;
      seconds_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      last_time_r <= last_time_nxt;
      time_left_r <= time_left_nxt;
      index_r     <= index_nxt;
      seconds_r   <= seconds_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    elapsed_r <= elapsed_nxt;
    now_r     <= now_nxt;
    fired_r   <= fired_nxt;
    prod_r    <= prod_nxt;
  end

  // Result register: load when done and free, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && out_free) begin
      out_fired_r <= fired_r;
      out_idx_r   <= index_r;
      out_sec_r   <= seconds_r;
      out_tot_r   <= prod_r + {{(sccc_pkg::CNT_W-VW){1'b0}}, index_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_fired_r;
  assign out_tdata  = {4'b0000, out_tot_r, out_sec_r, out_idx_r};

  sccc_div #(
    .DIV_W(DIV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  // Checks
  a_start_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside done state");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fired_r) |-> (out_idx_r < eff_rate))
    else $error("fired index not below sample rate");

endmodule
